// ----- src/hsvrgb_pkg.sv -----
// Shared types and constants for the dimmed HSV to RGB converter.
package hsvrgb_pkg;

  // Full scale of hue, saturation and level inputs.
  localparam logic [7:0]  SPAN      = 8'd254;
  // Full scale of an output channel.
  localparam logic [7:0]  CH_FULL   = 8'd255;
  // SPAN squared, the denominator of the ramp channel.
  localparam logic [23:0] SPAN_SQ   = 24'd64516;
  // Number of hue sectors below the wrap point.
  localparam int          NUM_SECT  = 6;
  // Number of pipeline stages.
  localparam int          NUM_STAGE = 7;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] level;
    logic       power_on;
  } hsv_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_out_t;

endpackage

// ----- src/hsv_to_rgb_dimmed.sv -----
// Dimmed HSV to RGB converter: seven-stage pipeline, top level.
// Throughput: one item per cycle while the output is not stalled; each stage
//   holds one item and advances when the stage after it is empty or
//   advancing, so bubbles close up under stall.
// Reset: synchronous active-low rst_n clears all stage valid bits; payload
//   registers are not reset.
module hsv_to_rgb_dimmed (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hsvrgb_pkg::hsv_in_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hsvrgb_pkg::rgb_out_t out_data
);

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYAN = 3'd2,
    SEC_CYAN_BLU = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5,
    SEC_WRAP     = 3'd6
  } sector_t;

  // ---------------------------------------------------------------- control
  logic [hsvrgb_pkg::NUM_STAGE-1:0] vld_r;
  logic [hsvrgb_pkg::NUM_STAGE-1:0] adv;

  always_comb begin
    adv[hsvrgb_pkg::NUM_STAGE-1] = !vld_r[hsvrgb_pkg::NUM_STAGE-1] || !out_stall;
    for (int k = hsvrgb_pkg::NUM_STAGE - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[hsvrgb_pkg::NUM_STAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < hsvrgb_pkg::NUM_STAGE; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Split hue*6 into sector and remainder, build the ramp's distance from
  // full (h) and the zero channel.
  logic [10:0] t_w;
  logic [10:0] base_w;
  sector_t     sec_nxt;
  logic [7:0]  f_w;
  logic [7:0]  h_nxt;
  logic [7:0]  v_w;
  logic [7:0]  zero_nxt;
  logic        off_nxt;

  always_comb begin
    t_w     = 11'({in_data.hue, 2'b00}) + 11'({in_data.hue, 1'b0});
    sec_nxt = SEC_RED_YEL;
    base_w  = '0;
    for (int k = 1; k <= hsvrgb_pkg::NUM_SECT; k++) begin
      if (t_w >= 11'(k * 254)) begin
        sec_nxt = sector_t'(3'(k));
        base_w  = 11'(k * 254);
      end
    end
    f_w   = 8'(t_w - base_w);
    // odd sector ramps down, so its distance from full is f itself
    h_nxt = sec_nxt[0] ? f_w : (hsvrgb_pkg::SPAN - f_w);
    // floor(255*v/254) = v + (v == 254) for v in 0..254
    v_w   = hsvrgb_pkg::SPAN - in_data.saturation;
    if (in_data.saturation == 8'hFF) begin
      zero_nxt = '0;
    end else begin
      zero_nxt = v_w + {7'd0, v_w == hsvrgb_pkg::SPAN};
    end
    off_nxt = !in_data.power_on || (in_data.level == 8'd0);
  end

  sector_t    sec1_r;
  logic [7:0] h1_r;
  logic [7:0] sat1_r;
  logic [7:0] zero1_r;
  logic [7:0] lvl1_r;
  logic       off1_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sec1_r  <= sec_nxt;
      h1_r    <= h_nxt;
      sat1_r  <= in_data.saturation;
      zero1_r <= zero_nxt;
      lvl1_r  <= in_data.level;
      off1_r  <= off_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Ramp numerator is 64516 - sat*h.
  logic [15:0] prod_nxt;
  assign prod_nxt = 16'(sat1_r) * 16'(h1_r);

  sector_t     sec2_r;
  logic [15:0] prod2_r;
  logic [7:0]  zero2_r;
  logic [7:0]  lvl2_r;
  logic        off2_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sec2_r  <= sec1_r;
      prod2_r <= prod_nxt;
      zero2_r <= zero1_r;
      lvl2_r  <= lvl1_r;
      off2_r  <= off1_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // x = 255*P; estimate x/64516 as (x*65) >> 22, low by at most one.
  logic [15:0] p_w;
  logic [23:0] x_nxt;
  logic [30:0] xm_w;
  logic [7:0]  q0_nxt;

  always_comb begin
    if (24'(prod2_r) >= hsvrgb_pkg::SPAN_SQ) begin
      p_w = '0;
    end else begin
      p_w = 16'(hsvrgb_pkg::SPAN_SQ - 24'(prod2_r));
    end
    x_nxt  = {p_w, 8'd0} - 24'(p_w);
    xm_w   = {x_nxt, 6'd0} + 31'(x_nxt) + 31'(x_nxt);
    xm_w   = xm_w - 31'(x_nxt);
    q0_nxt = 8'(xm_w >> 22);
  end

  sector_t     sec3_r;
  logic [23:0] x3_r;
  logic [7:0]  q3_r;
  logic [7:0]  zero3_r;
  logic [7:0]  lvl3_r;
  logic        off3_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sec3_r  <= sec2_r;
      x3_r    <= x_nxt;
      q3_r    <= q0_nxt;
      zero3_r <= zero2_r;
      lvl3_r  <= lvl2_r;
      off3_r  <= off2_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Correct the ramp quotient, then route full/ramp/zero by sector.
  logic [23:0] rem3_w;
  logic [7:0]  ramp_w;
  logic [7:0]  ch_nxt [3];

  always_comb begin
    rem3_w = x3_r - 24'(q3_r) * hsvrgb_pkg::SPAN_SQ;
    ramp_w = q3_r + {7'd0, rem3_w >= hsvrgb_pkg::SPAN_SQ};
    unique case (sec3_r)
      SEC_RED_YEL: begin
        ch_nxt[0] = hsvrgb_pkg::CH_FULL; ch_nxt[1] = ramp_w; ch_nxt[2] = zero3_r;
      end
      SEC_YEL_GRN: begin
        ch_nxt[0] = ramp_w; ch_nxt[1] = hsvrgb_pkg::CH_FULL; ch_nxt[2] = zero3_r;
      end
      SEC_GRN_CYAN: begin
        ch_nxt[0] = zero3_r; ch_nxt[1] = hsvrgb_pkg::CH_FULL; ch_nxt[2] = ramp_w;
      end
      SEC_CYAN_BLU: begin
        ch_nxt[0] = zero3_r; ch_nxt[1] = ramp_w; ch_nxt[2] = hsvrgb_pkg::CH_FULL;
      end
      SEC_BLU_MAG: begin
        ch_nxt[0] = ramp_w; ch_nxt[1] = zero3_r; ch_nxt[2] = hsvrgb_pkg::CH_FULL;
      end
      default: begin
        ch_nxt[0] = hsvrgb_pkg::CH_FULL; ch_nxt[1] = zero3_r; ch_nxt[2] = ramp_w;
      end
    endcase
  end

  logic [7:0] ch4_r [3];
  logic [7:0] lvl4_r;
  logic       off4_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int c = 0; c < 3; c++) begin
        ch4_r[c] <= ch_nxt[c];
      end
      lvl4_r <= lvl3_r;
      off4_r <= off3_r;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Dimming product per channel.
  logic [15:0] dim5_r [3];
  logic        off5_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int c = 0; c < 3; c++) begin
        dim5_r[c] <= 16'(ch4_r[c]) * 16'(lvl4_r);
      end
      off5_r <= off4_r;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // Estimate y/254 as (y*516) >> 17, low by at most one.
  logic [25:0] ym_w [3];
  logic [8:0]  dq6_r [3];
  logic [15:0] dim6_r [3];
  logic        off6_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ym_w[c] = {dim5_r[c], 9'd0} + 26'({dim5_r[c], 2'd0});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int c = 0; c < 3; c++) begin
        dq6_r[c]  <= 9'(ym_w[c] >> 17);
        dim6_r[c] <= dim5_r[c];
      end
      off6_r <= off5_r;
    end
  end

  // ---------------------------------------------------------------- stage 7
  // Correct the quotient, saturate, and blank when off.
  logic [15:0] drem_w [3];
  logic [8:0]  dq_w   [3];
  logic [7:0]  chan_w [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      drem_w[c] = dim6_r[c] - 16'(dq6_r[c]) * 16'(hsvrgb_pkg::SPAN);
      dq_w[c]   = dq6_r[c] + {8'd0, drem_w[c] >= 16'(hsvrgb_pkg::SPAN)};
      if (off6_r) begin
        chan_w[c] = '0;
      end else if (dq_w[c][8]) begin
        chan_w[c] = hsvrgb_pkg::CH_FULL;
      end else begin
        chan_w[c] = dq_w[c][7:0];
      end
    end
  end

  hsvrgb_pkg::rgb_out_t out_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      out_r.red   <= chan_w[0];
      out_r.green <= chan_w[1];
      out_r.blue  <= chan_w[2];
    end
  end

  assign out_data = out_r;

endmodule

// ----- src/hsvrgb_checker.sv -----
// Port-level checks for the dimmed HSV to RGB converter, bound to the top level.
module hsvrgb_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input hsvrgb_pkg::hsv_in_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input hsvrgb_pkg::rgb_out_t out_data
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Input backs up only when the pipeline is full and the output is held.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  // A stalled input item stays offered and unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("input item dropped or changed under stall");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("output valid dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("output item changed under stall");

endmodule

bind hsv_to_rgb_dimmed hsvrgb_checker u_hsvrgb_checker (.*);
